[rtl/oart_pkg.sv]
package oart_pkg;

    localparam int ID_W       = 16;
    localparam int REF_W      = 16;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int INTERVAL_W = 18;
    localparam int SLOT_OUT_W = 3;

    localparam logic [INTERVAL_W-1:0] MS_PER_SEC = INTERVAL_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 1'b1;

    localparam logic [CNT_W-1:0] RST_MAX_RETRIES = 8'd3;
    localparam logic [CNT_W-1:0] RST_RETRY_DELAY = 8'd30;

    typedef enum logic [1:0] {
        MODE_SEND   = 2'd0,
        MODE_ACK    = 2'd1,
        MODE_REJECT = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_SENT     = 2'd1,
        ST_ACKED    = 2'd2,
        ST_REJECTED = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        RES_DONE      = 2'd0,
        RES_FULL      = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_NONE      = 2'd3
    } t_res;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   msg_id;
        logic [REF_W-1:0]  message_ref;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_res                  status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       out_id;
        logic [REF_W-1:0]      out_ref;
        logic [CNT_W-1:0]      retry_number;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
        logic miss;
    } t_dp_cmd;

    typedef struct packed {
        logic ev_vld;
        logic hit;
        logic ev_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/oart_ctrl.sv]
module oart_ctrl import oart_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // hold the evaluated slot while the output register is still full
                priority if (i_stat.ev_vld && i_stat.hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_stat.ev_vld && i_stat.ev_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.miss = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/oart_dp.sv]
module oart_dp import oart_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_in_item,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [CNT_W-1:0]      r_max_retries;
    logic [CNT_W-1:0]      r_retry_delay;
    logic [INTERVAL_W-1:0] r_interval;
    logic [ID_W-1:0]       r_id_ctr;
    t_in_item              r_item;

    t_slot_st              r_status [SLOTS];
    logic [ID_W-1:0]       r_mem_id [SLOTS];
    logic [TIME_W-1:0]     r_mem_stamp [SLOTS];
    logic [CNT_W-1:0]      r_mem_retries [SLOTS];
    logic [REF_W-1:0]      r_mem_ref [SLOTS];

    logic [IW-1:0]         r_rd_idx;
    logic [IW-1:0]         r_ev_idx;
    logic                  r_ev_vld;
    t_slot_st              r_ev_status;
    logic [ID_W-1:0]       r_ev_id;
    logic [TIME_W-1:0]     r_ev_stamp;
    logic [CNT_W-1:0]      r_ev_retries;
    logic [REF_W-1:0]      r_ev_ref;

    logic                  r_out_valid;
    t_out_item             r_out_item;
    t_out_item             n_out_item;

    logic [TIME_W-1:0]     elapsed;
    logic                  due;
    logic                  hit;
    logic [ID_W-1:0]       n_id;
    logic [CNT_W-1:0]      n_retries;
    t_slot_st              n_status;
    logic                  out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= RST_MAX_RETRIES;
            r_retry_delay <= RST_RETRY_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data;
                CFG_RETRY_DELAY: r_retry_delay <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item     <= i_in_item;
            r_interval <= INTERVAL_W'(r_retry_delay * MS_PER_SEC);
        end
    end

    // scan pointers: read one slot a cycle unless a found result holds the scan, evaluate it the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_ev_idx <= '0;
            r_ev_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_rd_idx <= '0;
            r_ev_vld <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_rd_idx <= r_rd_idx + 1'b1;
            r_ev_idx <= r_rd_idx;
            r_ev_vld <= 1'b1;
        end
    end

    assign elapsed   = r_item.now_ms - r_ev_stamp;
    assign due       = (elapsed >= TIME_W'(r_interval));
    assign n_id      = r_id_ctr + 1'b1;
    assign n_retries = r_ev_retries + 1'b1;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_item.mode)
            MODE_SEND: begin
                hit      = (r_ev_status != ST_SENT);
                n_status = ST_SENT;
            end
            MODE_ACK: begin
                hit      = (r_ev_status != ST_EMPTY) && (r_ev_id == r_item.msg_id);
                n_status = ST_ACKED;
            end
            MODE_REJECT: begin
                hit      = (r_ev_status != ST_EMPTY) && (r_ev_id == r_item.msg_id);
                n_status = ST_REJECTED;
            end
            MODE_TICK: begin
                hit      = (r_ev_status == ST_SENT) && due
                           && (r_ev_retries < r_max_retries);
                n_status = ST_SENT;
            end
        endcase
    end

    assign o_stat = '{ev_vld: r_ev_vld, hit: hit, ev_last: (r_ev_idx == LAST_IDX),
                      out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_EMPTY;
            end
        end else if (i_cmd.commit) begin
            r_status[r_ev_idx] <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_ev_status <= r_status[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_ctr <= '0;
        end else if (i_cmd.commit && r_item.mode == MODE_SEND) begin
            r_id_ctr <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_item.mode == MODE_SEND) begin
            r_mem_id[r_ev_idx] <= n_id;
        end
        if (i_cmd.rd_en) begin
            r_ev_id <= r_mem_id[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_item.mode == MODE_SEND || r_item.mode == MODE_TICK)) begin
            r_mem_stamp[r_ev_idx] <= r_item.now_ms;
        end
        if (i_cmd.rd_en) begin
            r_ev_stamp <= r_mem_stamp[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_item.mode == MODE_SEND) begin
            r_mem_retries[r_ev_idx] <= '0;
        end else if (i_cmd.commit && r_item.mode == MODE_TICK) begin
            r_mem_retries[r_ev_idx] <= n_retries;
        end
        if (i_cmd.rd_en) begin
            r_ev_retries <= r_mem_retries[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_item.mode == MODE_SEND) begin
            r_mem_ref[r_ev_idx] <= r_item.message_ref;
        end
        if (i_cmd.rd_en) begin
            r_ev_ref <= r_mem_ref[r_rd_idx];
        end
    end

    always_comb begin
        n_out_item = '0;
        if (i_cmd.commit) begin
            n_out_item.status = RES_DONE;
            n_out_item.slot   = SLOT_OUT_W'(r_ev_idx);
            unique case (r_item.mode)
                MODE_SEND: begin
                    n_out_item.out_id  = n_id;
                    n_out_item.out_ref = r_item.message_ref;
                end
                MODE_ACK, MODE_REJECT: begin
                    n_out_item.out_id  = r_item.msg_id;
                    n_out_item.out_ref = r_ev_ref;
                end
                MODE_TICK: begin
                    n_out_item.out_id       = r_ev_id;
                    n_out_item.out_ref      = r_ev_ref;
                    n_out_item.retry_number = n_retries;
                end
            endcase
        end else begin
            unique case (r_item.mode)
                MODE_SEND:             n_out_item.status = RES_FULL;
                MODE_ACK, MODE_REJECT: n_out_item.status = RES_NOT_FOUND;
                MODE_TICK:             n_out_item.status = RES_NONE;
            endcase
        end
    end

    // output register: one result beat, taken when the far side stops stalling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.miss) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit || i_cmd.miss) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/outbox_ack_retry_table.sv]
// Flow: the item is registered when taken, then one slot is read per cycle; the
// first matching slot, or the last slot on a miss, sets o_out_valid once the output
// register is free. One item at a time: a new item is not taken until the result of
// the last one is in the output register; the scan is bounded by the single slot read port.
// Reset: all slots empty, id counter zero, max_retries 3, retry_delay_sec 30;
// slot contents are not cleared and there is no clearing pass.
module outbox_ack_retry_table import oart_pkg::*; #(
    parameter int SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    oart_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    oart_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

[tb/sv/tb_outbox_ack_retry_table.sv]
`timescale 1ns / 100ps

module tb_outbox_ack_retry_table;
    import oart_pkg::*;

    localparam int SLOTS           = 8;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int RANDOM_PER_CFG  = 120;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    outbox_ack_retry_table #(.SLOTS(SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the outbox table
    t_slot_st          tbl_st      [SLOTS];
    logic [ID_W-1:0]   tbl_id      [SLOTS];
    logic [TIME_W-1:0] tbl_stamp   [SLOTS];
    logic [CNT_W-1:0]  tbl_retries [SLOTS];
    logic [REF_W-1:0]  tbl_ref     [SLOTS];
    logic [ID_W-1:0]   next_id_count;
    logic [CNT_W-1:0]  cfg_max_retries;
    logic [CNT_W-1:0]  cfg_delay_sec;

    t_in_item          pending_msgs [$];
    t_out_item         expected_results [$];
    logic [TIME_W-1:0] sched_ms = '0;
    int                fail_count = 0;
    bit                fast = 1'b0;
    int                burst_left = 1;
    int                gap_left = 0;
    logic [7:0]        stall_mask = '0;
    logic [2:0]        stall_pos = '0;
    int                stall_win = 0;
    int                quiet_cycles = 0;

    function automatic t_out_item outbox_step(input t_in_item it);
        t_out_item         res;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] elapsed;
        bit                found;
        res = '0;
        found = 1'b0;
        interval = TIME_W'(cfg_delay_sec) * TIME_W'(1000);
        case (it.mode)
            MODE_SEND: begin
                for (int s = 0; s < SLOTS && !found; s++) begin
                    if (tbl_st[s] != ST_SENT) begin
                        next_id_count  = next_id_count + 1'b1;
                        tbl_st[s]      = ST_SENT;
                        tbl_id[s]      = next_id_count;
                        tbl_stamp[s]   = it.now_ms;
                        tbl_retries[s] = '0;
                        tbl_ref[s]     = it.message_ref;
                        res.slot       = SLOT_OUT_W'(s);
                        res.out_id     = next_id_count;
                        res.out_ref    = it.message_ref;
                        found = 1'b1;
                    end
                end
                if (!found) res.status = RES_FULL;
            end
            MODE_ACK, MODE_REJECT: begin
                for (int s = 0; s < SLOTS && !found; s++) begin
                    if (tbl_st[s] != ST_EMPTY && tbl_id[s] == it.msg_id) begin
                        tbl_st[s]   = (it.mode == MODE_ACK) ? ST_ACKED : ST_REJECTED;
                        res.slot    = SLOT_OUT_W'(s);
                        res.out_id  = it.msg_id;
                        res.out_ref = tbl_ref[s];
                        found = 1'b1;
                    end
                end
                if (!found) res.status = RES_NOT_FOUND;
            end
            default: begin
                for (int s = 0; s < SLOTS && !found; s++) begin
                    elapsed = it.now_ms - tbl_stamp[s];
                    if (tbl_st[s] == ST_SENT && elapsed >= interval &&
                        tbl_retries[s] < cfg_max_retries) begin
                        tbl_retries[s]   = tbl_retries[s] + 1'b1;
                        tbl_stamp[s]     = it.now_ms;
                        res.slot         = SLOT_OUT_W'(s);
                        res.out_id       = tbl_id[s];
                        res.out_ref      = tbl_ref[s];
                        res.retry_number = tbl_retries[s];
                        found = 1'b1;
                    end
                end
                if (!found) res.status = RES_NONE;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Sender: bursts of beats separated by random gaps
    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(outbox_step(i_in_item));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_msgs.size() != 0) begin
                    i_in_item  <= pending_msgs.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = (fast || $urandom_range(0, 3) == 0) ? 0
                                   : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a rotating mask, renewed when the stall window runs out
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, o_out_item);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", ID_W'(want.status), ID_W'(o_out_item.status));
                    check_field("slot", ID_W'(want.slot), ID_W'(o_out_item.slot));
                    check_field("out_id", want.out_id, o_out_item.out_id);
                    check_field("out_ref", want.out_ref, o_out_item.out_ref);
                    check_field("retry_number", ID_W'(want.retry_number),
                                ID_W'(o_out_item.retry_number));
                end
            end
            if (stall_win == 0) begin
                stall_win = 64;
                stall_mask = ($urandom_range(0, 3) == 0) ? 8'h00
                             : {7'($urandom_range(0, 127)), 1'b0};
            end
            stall_win--;
            stall_pos <= stall_pos + 1'b1;
            i_out_stall <= fast ? 1'b0 : stall_mask[stall_pos];
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_CYCLES) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic push_msg(input t_mode mode, input logic [ID_W-1:0] id,
                            input logic [REF_W-1:0] ref_h, input logic [TIME_W-1:0] now);
        t_in_item it;
        it.mode        = mode;
        it.msg_id      = id;
        it.message_ref = ref_h;
        it.now_ms      = now;
        pending_msgs.push_back(it);
    endtask

    task automatic wait_drain();
        while (pending_msgs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_MAX_RETRIES)
            cfg_max_retries = val;
        else
            cfg_delay_sec = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly live ids for acks and rejects, time advancing around the retry interval
    task automatic push_random_msg();
        t_in_item          it;
        int                r;
        int                live [$];
        logic [TIME_W-1:0] interval;
        interval = TIME_W'(cfg_delay_sec) * TIME_W'(1000);
        r = $urandom_range(0, 99);
        if (r < 50)
            sched_ms = sched_ms + TIME_W'($urandom_range(0, 2000));
        else if (r < 80)
            sched_ms = sched_ms + interval + TIME_W'($urandom_range(0, 2000));
        else if (r < 90)
            sched_ms = sched_ms;
        else if (r < 95)
            sched_ms = TIME_W'({$urandom, $urandom});
        else
            sched_ms = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 100000));
        for (int s = 0; s < SLOTS; s++)
            if (tbl_st[s] != ST_EMPTY) live.push_back(s);
        r = $urandom_range(0, 99);
        it.mode = (r < 35) ? MODE_SEND : (r < 55) ? MODE_ACK
                  : (r < 65) ? MODE_REJECT : MODE_TICK;
        r = $urandom_range(0, 99);
        if (live.size() != 0 && r < 75)
            it.msg_id = tbl_id[live[$urandom_range(0, live.size() - 1)]];
        else if (r < 85)
            it.msg_id = next_id_count + 1'b1;
        else
            it.msg_id = ID_W'($urandom_range(0, 16'hFFFF));
        it.message_ref = REF_W'($urandom_range(0, 16'hFFFF));
        it.now_ms      = sched_ms;
        pending_msgs.push_back(it);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            while (pending_msgs.size() != 0) @(negedge i_clk);
            push_random_msg();
        end
    endtask

    initial begin : main
        for (int s = 0; s < SLOTS; s++) begin
            tbl_st[s]      = ST_EMPTY;
            tbl_id[s]      = '0;
            tbl_stamp[s]   = '0;
            tbl_retries[s] = '0;
            tbl_ref[s]     = '0;
        end
        next_id_count   = '0;
        cfg_max_retries = RST_MAX_RETRIES;
        cfg_delay_sec   = RST_RETRY_DELAY;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the table, then one send too many
        push_msg(MODE_SEND, 16'h0000, 16'h0000, 48'd0);
        push_msg(MODE_SEND, 16'hFFFF, 16'hFFFF, 48'd0);
        for (int n = 1; n <= 6; n++)
            push_msg(MODE_SEND, 16'h0000, REF_W'(n), 48'd0);
        push_msg(MODE_SEND, 16'h0000, 16'h1234, 48'd10);
        // Just short of the interval, then exactly on it
        push_msg(MODE_TICK, 16'h0000, 16'h0000, 48'd29999);
        push_msg(MODE_TICK, 16'h0000, 16'h0000, 48'd30000);
        push_msg(MODE_ACK, 16'd3, 16'h0000, 48'd30001);
        push_msg(MODE_REJECT, 16'd5, 16'h0000, 48'd30002);
        // Finished messages still match and get overwritten
        push_msg(MODE_ACK, 16'd3, 16'h0000, 48'd30003);
        push_msg(MODE_REJECT, 16'd3, 16'h0000, 48'd30004);
        push_msg(MODE_ACK, 16'hFFFF, 16'hFFFF, 48'd30005);
        push_msg(MODE_REJECT, 16'h0000, 16'h0000, 48'd30006);
        push_msg(MODE_SEND, 16'h0000, 16'hA5A5, 48'd40000);
        // Time at the top of its range, then wrapped round past zero
        push_msg(MODE_TICK, 16'h0000, 16'h0000, {TIME_W{1'b1}});
        push_msg(MODE_TICK, 16'h0000, 16'h0000, {TIME_W{1'b1}});
        push_msg(MODE_TICK, 16'h0000, 16'h0000, 48'd100);
        // Run slot 0 out of retries
        for (int n = 1; n <= 5; n++)
            push_msg(MODE_TICK, 16'h0000, 16'h0000, TIME_W'(n * 100000));
        sched_ms = 48'd600000;
        wait_drain();

        run_random(RANDOM_PER_CFG);
        wait_drain();
        write_cfg(CFG_MAX_RETRIES, 8'd0);
        write_cfg(CFG_RETRY_DELAY, 8'd0);
        run_random(RANDOM_PER_CFG);
        wait_drain();
        write_cfg(CFG_MAX_RETRIES, 8'd255);
        write_cfg(CFG_RETRY_DELAY, 8'd255);
        run_random(RANDOM_PER_CFG);
        wait_drain();
        write_cfg(CFG_RETRY_DELAY, 8'd1);
        write_cfg(CFG_MAX_RETRIES, 8'd2);
        run_random(RANDOM_PER_CFG);
        wait_drain();
        write_cfg(CFG_MAX_RETRIES, CFG_W'($urandom_range(0, 255)));
        write_cfg(CFG_RETRY_DELAY, CFG_W'($urandom_range(0, 255)));
        run_random(RANDOM_PER_CFG);
        wait_drain();

        // Free every busy slot back to back
        fast = 1'b1;
        for (int s = 0; s < SLOTS; s++)
            if (tbl_st[s] == ST_SENT) push_msg(MODE_ACK, tbl_id[s], 16'h0000, sched_ms);
        wait_drain();
        fast = 1'b0;

        repeat (SLOTS + 4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0t: results missing, expected %0d more, got 0",
                     $time, expected_results.size());
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/oart_pkg.sv
rtl/oart_ctrl.sv
rtl/oart_dp.sv
rtl/outbox_ack_retry_table.sv
tb/sv/tb_outbox_ack_retry_table.sv
